### hw/rtl/sliding_window_rms_meter_unit_macros.svh
// assertion macros for the sliding window rms meter
`ifndef SLIDING_WINDOW_RMS_METER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_RMS_METER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define SWRMS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");
// next-cycle implication, checked out of reset
`define SWRMS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");
`else
`define SWRMS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define SWRMS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

### hw/rtl/swrms_pkg.sv
// types and constants shared by the rms meter files
`timescale 1ns / 1ps
`default_nettype none

package swrms_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;
    localparam int LEVEL_W     = 16;
    localparam int REM_W       = LEVEL_W + 2;
    localparam int RADICAND_W  = 2 * LEVEL_W;
    localparam int ROOT_STEPS  = LEVEL_W;
    localparam int STEP_W      = $clog2(ROOT_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_ROOT,
        ST_DONE
    } swrms_state_t;

endpackage

`default_nettype wire

### hw/rtl/swrms_ram.sv
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module swrms_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_rms_meter_unit.sv
// sliding window rms meter: top level with sequencer, running total and square root
`timescale 1ns / 1ps
`default_nettype none

// Sliding window RMS meter. Each sample beat carries one signed Q1.15 sample;
// the block squares it, replaces the oldest of WINDOW stored squares with it,
// keeps a running total of the window and returns one level beat holding
// floor(sqrt(total / WINDOW)) on the same Q1.15 scale (0 to 32768). The
// window always divides by its full length, so the level ramps up over the
// first WINDOW samples after reset. One sample at a time is in flight; from
// acceptance to its level being offered it is squared while the old square
// is read from the ring memory, then updates the total and writes the ring,
// then passes through the bit-serial square root (one result bit per cycle)
// and is loaded into the output register, which waits while an earlier level
// beat is still held. A level beat that waits for its consumer does not block
// the next sample from being accepted and squared. The ring memory needs no
// clearing pass after reset: until the write position first wraps, the old
// entry is taken as zero, so the block is ready as soon as reset is released.
// WINDOW must be a power of two from 2 to 4096.

module sliding_window_rms_meter_unit
    import swrms_pkg::*;
#(
    parameter int WINDOW = 256
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] audio_sample,
    output logic                            level_valid,
    input  wire logic                       level_ready,
    output logic             [LEVEL_W-1:0]  rms_level
);

    `include "sliding_window_rms_meter_unit_macros.svh"

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int TOTAL_W = SQUARE_W + IDX_W;
    // largest total: a window full of the most negative sample
    localparam logic [TOTAL_W:0] TOTAL_MAX = (TOTAL_W + 1)'(1) << (TOTAL_W - 1);

    swrms_state_t state_reg, state_next;

    // sequencer strobes
    logic sample_take;
    logic ring_update;
    logic root_step;
    logic level_load;

    // datapath registers
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic        [SQUARE_W-1:0]   square_reg;
    logic        [TOTAL_W-1:0]    total_reg, total_next;
    logic        [IDX_W-1:0]      pos_reg;
    logic                         filled_reg;
    logic        [RADICAND_W-1:0] radicand_reg;
    logic        [REM_W-1:0]      rem_reg;
    logic        [LEVEL_W-1:0]    root_reg;
    logic        [STEP_W-1:0]     step_reg;
    logic                         level_valid_reg;
    logic        [LEVEL_W-1:0]    level_reg;

    // ring memory read data and product
    logic        [SQUARE_W-1:0]   old_square;
    logic        [SQUARE_W-1:0]   old_effective;
    logic signed [2*SAMPLE_W-1:0] product;

    // square root step
    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic             trial_fits;

    // ---------------------------------------------------------------
    // ring of squares
    // ---------------------------------------------------------------
    swrms_ram
    #(
        .WIDTH (SQUARE_W),
        .DEPTH (WINDOW)
    )
    u_ring
    (
        .clk   (clk),
        .we    (ring_update),
        .waddr (pos_reg),
        .wdata (square_reg),
        .re    (sample_take),
        .raddr (pos_reg),
        .rdata (old_square)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        sample_take  = 1'b0;
        ring_update  = 1'b0;
        root_step    = 1'b0;
        level_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    sample_take = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ring_update = 1'b1;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                root_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!level_valid_reg || level_ready)
                begin
                    level_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // square and running total
    // ---------------------------------------------------------------
    assign product       = sample_reg * sample_reg;
    // entries not yet written since reset count as zero
    assign old_effective = filled_reg ? old_square : '0;
    assign total_next    = total_reg - TOTAL_W'(old_effective) + TOTAL_W'(square_reg);

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            sample_reg <= audio_sample;
        end
        if (state_reg == ST_SQUARE)
        begin
            square_reg <= product[SQUARE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (ring_update)
        begin
            total_reg <= total_next;
            pos_reg   <= pos_reg + IDX_W'(1);
            if (&pos_reg)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // bit-serial floor square root of the window mean
    // ---------------------------------------------------------------
    assign rem_shift  = {rem_reg, radicand_reg[RADICAND_W-1 -: 2]};
    assign trial      = {2'b00, root_reg, 2'b01};
    assign trial_fits = rem_shift >= trial;

    always_ff @(posedge clk)
    begin
        if (ring_update)
        begin
            // mean is the total shifted down by log2 of the window
            radicand_reg <= RADICAND_W'(total_next[TOTAL_W-1:IDX_W]);
            rem_reg      <= '0;
            root_reg     <= '0;
            step_reg     <= STEP_W'(ROOT_STEPS - 1);
        end
        else if (root_step)
        begin
            radicand_reg <= {radicand_reg[RADICAND_W-3:0], 2'b00};
            step_reg     <= step_reg - STEP_W'(1);
            if (trial_fits)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_valid_reg <= 1'b0;
        end
        else if (level_load)
        begin
            level_valid_reg <= 1'b1;
        end
        else if (level_ready)
        begin
            level_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (level_load)
        begin
            level_reg <= root_reg;
        end
    end

    assign level_valid = level_valid_reg;
    assign rms_level   = level_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `SWRMS_ASSERT_NEXT(a_take_starts_square, clk, rst_n, sample_take, state_reg == ST_SQUARE)
    `SWRMS_ASSERT_NEXT(a_root_ends_done, clk, rst_n, root_step && step_reg == '0, state_reg == ST_DONE)
    `SWRMS_ASSERT_NOW(a_total_bounded, clk, rst_n, 1'b1, {1'b0, total_reg} <= TOTAL_MAX)
    `SWRMS_ASSERT_NEXT(a_load_shows_level, clk, rst_n, level_load, level_valid && rms_level == $past(root_reg))

endmodule

`default_nettype wire

### tb/tb_sliding_window_rms_meter_unit.sv
// self-checking testbench for the sliding window rms meter unit
`timescale 1ns / 1ps

module tb_sliding_window_rms_meter_unit
    import swrms_pkg::*;
;

    // window geometry as built into the unit under test
    localparam int WINDOW_LEN       = 256;
    localparam int WINDOW_SHIFT     = $clog2(WINDOW_LEN);
    localparam int TOTAL_W          = SQUARE_W + WINDOW_SHIFT;

    // span from sample acceptance to level beat, one sample in flight
    localparam int PIPE_CYCLES      = 19;
    localparam int SETTLE_CYCLES    = 4 * PIPE_CYCLES;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int FULL_RUN         = WINDOW_LEN + 4;
    localparam int NUM_PHASES       = 4;

    // window of squares, running total and expected level beats
    class rms_scoreboard;
        logic [SQUARE_W-1:0]     square_ring [WINDOW_LEN];
        logic [TOTAL_W-1:0]      window_total;
        logic [WINDOW_SHIFT-1:0] write_idx;
        logic [LEVEL_W-1:0]      pending_levels [$];
        int samples_seen;
        int levels_seen;
        int mismatches;
        int full_scale_hits;

        function new();
            foreach (square_ring[i])
                square_ring[i] = '0;
            window_total    = '0;
            write_idx       = '0;
            samples_seen    = 0;
            levels_seen     = 0;
            mismatches      = 0;
            full_scale_hits = 0;
        endfunction

        // largest root whose square does not exceed the radicand, msb first
        function logic [LEVEL_W-1:0] floor_root(logic [2*LEVEL_W-1:0] radicand);
            logic [LEVEL_W-1:0]   root;
            logic [LEVEL_W-1:0]   trial;
            logic [2*LEVEL_W-1:0] trial_sq;
            root = '0;
            for (int b = LEVEL_W - 1; b >= 0; b--)
            begin
                trial    = root | (LEVEL_W'(1) << b);
                trial_sq = trial * trial;
                if (trial_sq <= radicand)
                    root = trial;
            end
            return root;
        endfunction

        // accepted sample beat: update the window and queue its level
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            logic [SAMPLE_W:0]    magnitude;
            logic [SQUARE_W-1:0]  square;
            logic [TOTAL_W-1:0]   mean;
            // 17 bits so that the most negative sample gives 32768
            magnitude = s[SAMPLE_W-1] ? -{s[SAMPLE_W-1], s} : {1'b0, s};
            square    = magnitude * magnitude;
            window_total = window_total - square_ring[write_idx] + square;
            square_ring[write_idx] = square;
            write_idx = write_idx + 1'b1;
            mean = window_total >> WINDOW_SHIFT;
            pending_levels.push_back(floor_root(mean[2*LEVEL_W-1:0]));
            samples_seen++;
        endfunction

        // accepted level beat: compare with the oldest queued level
        function void check_level(logic [LEVEL_W-1:0] got);
            logic [LEVEL_W-1:0] want;
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                $display("%0t: level beat %0d arrived with no sample outstanding",
                         $time, got);
                return;
            end
            want = pending_levels.pop_front();
            levels_seen++;
            if (want == LEVEL_W'(32768))
                full_scale_hits++;
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: rms_level mismatch on level %0d, expected %0d, got %0d",
                         $time, levels_seen, want, got);
            end
        endfunction

        function int outstanding();
            return pending_levels.size();
        endfunction
    endclass

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] audio_sample = '0;
    logic                       level_valid;
    logic                       level_ready  = 1'b0;
    logic        [LEVEL_W-1:0]  rms_level;

    rms_scoreboard levels_sb;

    // idle mix of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // receiver hold-off handshake between the main flow and the receiver
    bit long_hold_request = 1'b0;
    int long_holds_done   = 0;
    int quiet_cycles      = 0;

    int sender_idle_by_phase   [NUM_PHASES] = '{0, 55, 0, 29};
    int receiver_stall_by_phase[NUM_PHASES] = '{0, 0, 55, 29};

    // signs, extremes, single bits and alternating patterns
    logic signed [SAMPLE_W-1:0] corner_samples [18] = '{
        16'sh0000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001, 16'sh8001,
        16'sh4000, 16'shC000, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00,
        16'sh0100, 16'sh00B5, 16'sh7FFE, 16'sh8000, 16'sh8000, 16'sh0000
    };

    sliding_window_rms_meter_unit #(
        .WINDOW (WINDOW_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .audio_sample (audio_sample),
        .level_valid  (level_valid),
        .level_ready  (level_ready),
        .rms_level    (rms_level)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                level_ready <= 1'b0;
                // counted here so the sender keeps pushing and the unit backs up
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
                long_holds_done++;
            end
            else
            begin
                level_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // beat monitor: level beat checked before the sample beat of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (level_valid && level_ready)
                levels_sb.check_level(rms_level);
            if (sample_valid && sample_ready)
                levels_sb.note_sample(audio_sample);
            if ((level_valid && level_ready) || (sample_valid && sample_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles in which no beat moves
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles, %0d levels outstanding",
                     $time, quiet_cycles, levels_sb.outstanding());
            $display("sliding_window_rms_meter_unit verification failed");
            $finish;
        end
    end

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        audio_sample <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    task automatic send_run(input logic signed [SAMPLE_W-1:0] value, input int count);
        for (int n = 0; n < count; n++)
            send_sample(value);
    endtask

    // sender stops until every queued level has come back
    task automatic pause_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (levels_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    initial
    begin
        int                         sent;
        int                         kind;
        int                         run_len;
        logic signed [SAMPLE_W-1:0] value;

        levels_sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners while the window is still ramping up from zeros
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        // full windows at both ends of the scale: 32768 and then 32767
        send_run(16'sh8000, FULL_RUN);
        send_run(16'sh7FFF, FULL_RUN);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = sender_idle_by_phase[phase];
            recv_stall_pct = receiver_stall_by_phase[phase];

            // receiver holds off while samples keep coming, so the input stalls
            if (phase == 0)
            begin
                long_hold_request = 1'b1;
                for (int n = 0; n < 12; n++)
                    send_sample(SAMPLE_W'($urandom));
            end

            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                kind = $urandom_range(9);
                if (kind < 5)
                begin
                    send_sample(SAMPLE_W'($urandom));
                    sent++;
                end
                else if (kind < 7)
                begin
                    // quiet signal, near zero on either side
                    value = SAMPLE_W'($urandom_range(511)) - 16'sd256;
                    send_sample(value);
                    sent++;
                end
                else
                begin
                    // steady tone segment: constant value, extreme or random
                    run_len = $urandom_range(64, 2);
                    value   = ($urandom_range(1) == 0) ? pick_extreme()
                                                        : SAMPLE_W'($urandom);
                    send_run(value, run_len);
                    sent += run_len;
                end

                // mid-phase the sender waits for the pipe to empty
                if (phase == 2 && sent >= RANDOM_PER_PHASE / 2
                    && sent - run_len < RANDOM_PER_PHASE / 2)
                    pause_until_drained();
            end
            pause_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d samples and %0d level beats, %0d full-scale levels",
                 levels_sb.samples_seen, levels_sb.levels_seen, levels_sb.full_scale_hits);
        $display("idle mixes none, sender, receiver and both; %0d long receiver hold-offs",
                 long_holds_done);
        if (levels_sb.mismatches == 0 && levels_sb.outstanding() == 0)
        begin
            $display("sliding_window_rms_meter_unit verification clean");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d levels never arrived",
                     $time, levels_sb.mismatches, levels_sb.outstanding());
            $display("sliding_window_rms_meter_unit verification failed");
        end
        $finish;
    end

endmodule
